>>> hdl/lsfp_pkg.sv
package lsfp_pkg;

    // sample and grid geometry
    localparam int SampleW   = 32;
    localparam int RowCount  = 4;
    localparam int CellCount = 5;

    // column counter, saturates at its all-ones value
    localparam int CountW         = 10;
    localparam int ColumnsDefault = 256;

    typedef logic signed [SampleW-1:0] sample_t;
    typedef sample_t [RowCount-1:0]    column_t;

    // stage enables for the two-stage Laplacian unit
    typedef struct packed {
        logic sum_en;
        logic sat_en;
    } lap_ctrl_t;

endpackage

>>> hdl/lsfp_if.sv
// column transaction: one grid column of four rows
interface lsfp_in_if;
    import lsfp_pkg::*;

    logic    valid;
    logic    ready;
    logic    row_start;
    sample_t row1_sample;
    sample_t row2_sample;
    sample_t row3_sample;
    sample_t row4_sample;

    modport source (
        output valid, row_start, row1_sample, row2_sample, row3_sample, row4_sample,
        input  ready
    );
    modport sink (
        input  valid, row_start, row1_sample, row2_sample, row3_sample, row4_sample,
        output ready
    );
endinterface

// result transaction: four Laplacians and an end-of-row flag
interface lsfp_out_if;
    import lsfp_pkg::*;

    logic    valid;
    logic    ready;
    sample_t lap_west;
    sample_t lap_mid;
    sample_t lap_east;
    sample_t lap_down;
    logic    row_last;

    modport source (
        output valid, lap_west, lap_mid, lap_east, lap_down, row_last,
        input  ready
    );
    modport sink (
        input  valid, lap_west, lap_mid, lap_east, lap_down, row_last,
        output ready
    );
endinterface

>>> hdl/lsfp_cell.sv
// One window cell: holds a grid column and passes it to the older neighbour
module lsfp_cell (
    input  logic             clk,
    input  logic             shift,
    input  lsfp_pkg::column_t col_in,
    output lsfp_pkg::column_t col_out
);
    import lsfp_pkg::*;

    column_t col_reg;

    // take the newer column on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

>>> hdl/lsfp_lap.sv
// Five-point Laplacian, 4*centre - up - down - left - right, saturated.
// Stage 1 forms the vertical and horizontal partial sums, stage 2 combines
// and clamps.
module lsfp_lap (
    input  logic                clk,
    input  lsfp_pkg::lap_ctrl_t ctrl,
    input  lsfp_pkg::sample_t   centre,
    input  lsfp_pkg::sample_t   up,
    input  lsfp_pkg::sample_t   down,
    input  lsfp_pkg::sample_t   left,
    input  lsfp_pkg::sample_t   right,
    output lsfp_pkg::sample_t   lap
);
    import lsfp_pkg::*;

    localparam int VertW = SampleW + 3;
    localparam int HorzW = SampleW + 1;
    localparam int SumW  = SampleW + 4;

    logic signed [VertW-1:0] vert_reg;
    logic signed [VertW-1:0] vert_next;
    logic signed [HorzW-1:0] horz_reg;
    logic signed [HorzW-1:0] horz_next;
    logic signed [SumW-1:0]  total;
    sample_t                 lap_reg;
    sample_t                 lap_next;

    // partial sums
    assign vert_next = (VertW'(centre) <<< 2) - VertW'(up) - VertW'(down);
    assign horz_next = HorzW'(left) + HorzW'(right);

    // combine and clamp to the sample range
    always_comb
    begin
        total = SumW'(vert_reg) - SumW'(horz_reg);
        if (total[SumW-1:SampleW-1] == '0 || total[SumW-1:SampleW-1] == '1)
        begin
            lap_next = total[SampleW-1:0];
        end
        else if (total[SumW-1])
        begin
            lap_next = {1'b1, {(SampleW-1){1'b0}}};
        end
        else
        begin
            lap_next = {1'b0, {(SampleW-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            vert_reg <= vert_next;
            horz_reg <= horz_next;
        end
        if (ctrl.sat_en)
        begin
            lap_reg <= lap_next;
        end
    end

    assign lap = lap_reg;

endmodule

>>> hdl/laplacian_stencil_four_point.sv
// Five-point Laplacian stencil over a stream of four-row grid columns. One
// column transaction is taken per clock cycle unless back-pressure has
// filled the pipeline; a column passes through the column window, then the
// partial-sum stage, then the output register. The column window, the
// partial-sum stage and the output register each hold only while the stage
// after them is full and stalled, so bubbles close up under back-pressure.
// A row of COLUMNS+4 columns gives COLUMNS results: the first four columns
// after row_start (or after reset) only fill the five-cell column window and
// give none. Throughput is set by the column window, which shifts once per
// accepted transaction; each Laplacian is one partial-sum stage (35-bit
// vertical, 33-bit horizontal) followed by one 36-bit subtract-and-clamp stage.
module laplacian_stencil_four_point #(
    parameter int COLUMNS = lsfp_pkg::ColumnsDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    lsfp_in_if.sink           columns,
    lsfp_out_if.source        laplacians
);
    import lsfp_pkg::*;

    localparam logic [CountW-1:0] CountMax  = '1;
    localparam logic [CountW-1:0] FirstEmit = CountW'(CellCount);
    localparam logic [CountW-1:0] LastCount = CountW'(COLUMNS + CellCount - 1);

    // pipeline control
    logic              pend_valid_reg;
    logic              pend_last_reg;
    logic              sum_valid_reg;
    logic              sum_last_reg;
    logic              out_valid_reg;
    logic              out_last_reg;
    logic [CountW-1:0] count_reg;
    logic [CountW-1:0] count_base;
    logic [CountW-1:0] count_next;
    logic              en_pend;
    logic              en_sum;
    logic              en_out;
    logic              accept;
    lap_ctrl_t         lap_ctrl;

    column_t           in_column;
    column_t           cell_col  [CellCount];
    column_t           cell_feed [CellCount];

    // each stage moves when it is empty or the next one moves
    assign en_out  = !out_valid_reg || laplacians.ready;
    assign en_sum  = !sum_valid_reg || en_out;
    assign en_pend = !pend_valid_reg || en_sum;
    assign accept  = columns.valid && en_pend;

    assign columns.ready = en_pend;

    assign lap_ctrl.sum_en = en_sum;
    assign lap_ctrl.sat_en = en_out;

    // column counter, restarted by row_start
    always_comb
    begin
        count_base = columns.row_start ? '0 : count_reg;
        count_next = (count_base < CountMax) ? count_base + 1'b1 : count_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_last_reg  <= 1'b0;
            sum_last_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (en_pend)
            begin
                pend_valid_reg <= accept && (count_next >= FirstEmit);
                pend_last_reg  <= count_next == LastCount;
            end
            if (en_sum)
            begin
                sum_valid_reg <= pend_valid_reg;
                sum_last_reg  <= pend_last_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= sum_valid_reg;
                out_last_reg  <= sum_last_reg;
            end
        end
    end

    // column window: cell 4 newest, cell 0 oldest
    assign in_column[0] = columns.row1_sample;
    assign in_column[1] = columns.row2_sample;
    assign in_column[2] = columns.row3_sample;
    assign in_column[3] = columns.row4_sample;

    for (genvar k = 0; k < CellCount; k++)
    begin : g_cell
        if (k == CellCount - 1)
        begin : g_head
            assign cell_feed[k] = in_column;
        end
        else
        begin : g_body
            assign cell_feed[k] = cell_col[k+1];
        end

        lsfp_cell u_cell (
            .clk     (clk),
            .shift   (accept),
            .col_in  (cell_feed[k]),
            .col_out (cell_col[k])
        );
    end

    // Laplacian units
    lsfp_lap u_lap_west (
        .clk    (clk),
        .ctrl   (lap_ctrl),
        .centre (cell_col[1][1]),
        .up     (cell_col[1][0]),
        .down   (cell_col[1][2]),
        .left   (cell_col[0][1]),
        .right  (cell_col[2][1]),
        .lap    (laplacians.lap_west)
    );

    lsfp_lap u_lap_mid (
        .clk    (clk),
        .ctrl   (lap_ctrl),
        .centre (cell_col[2][1]),
        .up     (cell_col[2][0]),
        .down   (cell_col[2][2]),
        .left   (cell_col[1][1]),
        .right  (cell_col[3][1]),
        .lap    (laplacians.lap_mid)
    );

    lsfp_lap u_lap_east (
        .clk    (clk),
        .ctrl   (lap_ctrl),
        .centre (cell_col[3][1]),
        .up     (cell_col[3][0]),
        .down   (cell_col[3][2]),
        .left   (cell_col[2][1]),
        .right  (cell_col[4][1]),
        .lap    (laplacians.lap_east)
    );

    lsfp_lap u_lap_down (
        .clk    (clk),
        .ctrl   (lap_ctrl),
        .centre (cell_col[2][2]),
        .up     (cell_col[2][1]),
        .down   (cell_col[2][3]),
        .left   (cell_col[1][2]),
        .right  (cell_col[3][2]),
        .lap    (laplacians.lap_down)
    );

    assign laplacians.valid    = out_valid_reg;
    assign laplacians.row_last = out_last_reg;

    // full pipeline with a stalled output takes no column
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && sum_valid_reg && out_valid_reg && !laplacians.ready
        |-> !columns.ready)
        else $error("column taken while pipeline is full and stalled");

    // row_start restarts the count at one
    a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && columns.row_start |=> count_reg == 1)
        else $error("column count not restarted by row_start");

    // within a row the count never falls
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !columns.row_start |=> count_reg >= $past(count_reg))
        else $error("column count fell within a row");

    // a result only appears after passing the sum stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(sum_valid_reg))
        else $error("result valid without a summed transaction");

endmodule
